### rtl/core/mmsfr_pkg.sv
// Shared widths, constants and helpers for the minmod face reconstruction block.
package mmsfr_pkg;

   localparam int DataWidth  = 32;
   localparam int FracBits   = 16;
   localparam int BetaWidth  = 18;
   localparam int NumInputs  = 7;
   localparam int NumOutputs = 6;

   // exact difference of two inputs
   localparam int DiffWidth  = DataWidth + 1;
   // difference times beta (beta taken as signed, one bit wider)
   localparam int ProdWidth  = DiffWidth + BetaWidth + 1;
   // candidate slopes after dropping the fraction bits
   localparam int SlopeWidth = ProdWidth - FracBits;
   // centre plus or minus half slope, before saturation
   localparam int FaceWidth  = SlopeWidth + 1;

   localparam int ReqDataWidth = DataWidth * NumInputs;
   localparam int RspDataWidth = DataWidth * NumOutputs;

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam int CsrIdxWidth  = CsrAddrWidth - 2;

   localparam logic [CsrIdxWidth-1:0] CsrIdxSlopeBeta = CsrIdxWidth'(0);
   localparam logic [BetaWidth-1:0]   BetaReset       = BetaWidth'(65536);

   typedef logic signed [DataWidth-1:0]  data_type;
   typedef logic signed [SlopeWidth-1:0] slope_type;
   typedef logic signed [FaceWidth-1:0]  face_sum_type;

   // Clamp a wide face sum to the signed output range.
   function automatic data_type sat_face(input face_sum_type v);
      data_type r;
      if (v[FaceWidth-1] && !(&v[FaceWidth-2:DataWidth-1])) begin
         r = {1'b1, {(DataWidth-1){1'b0}}};
      end else if (!v[FaceWidth-1] && (|v[FaceWidth-2:DataWidth-1])) begin
         r = {1'b0, {(DataWidth-1){1'b1}}};
      end else begin
         r = v[DataWidth-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/mmsfr_axis.sv
// One axis: beta-scaled and central slope candidates, minmod limit, two face values.
module mmsfr_axis (
   input  logic                                clock,
   input  logic                                stage_load,
   input  logic signed [mmsfr_pkg::DataWidth-1:0] center_value,
   input  logic signed [mmsfr_pkg::DataWidth-1:0] plus_value,
   input  logic signed [mmsfr_pkg::DataWidth-1:0] minus_value,
   input  logic [mmsfr_pkg::BetaWidth-1:0]      slope_beta,
   input  logic signed [mmsfr_pkg::DataWidth-1:0] center_hold,
   output logic signed [mmsfr_pkg::DataWidth-1:0] plus_face,
   output logic signed [mmsfr_pkg::DataWidth-1:0] minus_face
);

   logic signed [mmsfr_pkg::DiffWidth-1:0] fwd_diff;
   logic signed [mmsfr_pkg::DiffWidth-1:0] bwd_diff;
   logic signed [mmsfr_pkg::DiffWidth-1:0] cen_diff;
   logic signed [mmsfr_pkg::BetaWidth:0]   beta_signed;
   logic signed [mmsfr_pkg::ProdWidth-1:0] fwd_prod;
   logic signed [mmsfr_pkg::ProdWidth-1:0] bwd_prod;

   mmsfr_pkg::slope_type fwd_in, cen_in, bwd_in;
   mmsfr_pkg::slope_type fwd_ff, cen_ff, bwd_ff;
   mmsfr_pkg::slope_type low_fc, high_fc, slope, half_slope;
   mmsfr_pkg::face_sum_type plus_sum, minus_sum;
   logic all_pos, all_neg;

   // candidate slopes
   assign fwd_diff = mmsfr_pkg::DiffWidth'(plus_value) - mmsfr_pkg::DiffWidth'(center_value);
   assign bwd_diff = mmsfr_pkg::DiffWidth'(center_value) - mmsfr_pkg::DiffWidth'(minus_value);
   assign cen_diff = mmsfr_pkg::DiffWidth'(plus_value) - mmsfr_pkg::DiffWidth'(minus_value);
   assign beta_signed = $signed({1'b0, slope_beta});
   assign fwd_prod = fwd_diff * beta_signed;
   assign bwd_prod = bwd_diff * beta_signed;

   // drop fraction bits: arithmetic shift, so rounding goes toward minus infinity
   assign fwd_in = $signed(fwd_prod[mmsfr_pkg::ProdWidth-1:mmsfr_pkg::FracBits]);
   assign bwd_in = $signed(bwd_prod[mmsfr_pkg::ProdWidth-1:mmsfr_pkg::FracBits]);
   assign cen_in = mmsfr_pkg::SlopeWidth'($signed(cen_diff[mmsfr_pkg::DiffWidth-1:1]));

   always_ff @(posedge clock) begin
      if (stage_load) begin
         fwd_ff <= fwd_in;
         cen_ff <= cen_in;
         bwd_ff <= bwd_in;
      end
   end

   // minmod: smallest magnitude is the signed min when all positive, max when all negative
   always_comb begin
      all_pos = !fwd_ff[mmsfr_pkg::SlopeWidth-1] && (fwd_ff != '0)
             && !cen_ff[mmsfr_pkg::SlopeWidth-1] && (cen_ff != '0)
             && !bwd_ff[mmsfr_pkg::SlopeWidth-1] && (bwd_ff != '0);
      all_neg = fwd_ff[mmsfr_pkg::SlopeWidth-1] && cen_ff[mmsfr_pkg::SlopeWidth-1]
             && bwd_ff[mmsfr_pkg::SlopeWidth-1];
      low_fc  = (fwd_ff < cen_ff) ? fwd_ff : cen_ff;
      high_fc = (fwd_ff > cen_ff) ? fwd_ff : cen_ff;
      priority if (all_pos) begin
         slope = (bwd_ff < low_fc) ? bwd_ff : low_fc;
      end else if (all_neg) begin
         slope = (bwd_ff > high_fc) ? bwd_ff : high_fc;
      end else begin
         slope = '0;
      end
      half_slope = slope >>> 1;
      plus_sum  = mmsfr_pkg::FaceWidth'(center_hold) + mmsfr_pkg::FaceWidth'(half_slope);
      minus_sum = mmsfr_pkg::FaceWidth'(center_hold) - mmsfr_pkg::FaceWidth'(half_slope);
   end

   assign plus_face  = mmsfr_pkg::sat_face(plus_sum);
   assign minus_face = mmsfr_pkg::sat_face(minus_sum);

endmodule

### rtl/core/minmod_slope_face_reconstruction.sv
// MUSCL face reconstruction with a three-way minmod slope limiter, Q16.16 in and out.
// Each transfer on the req side carries a cell value and its six axis neighbors and yields
// one transfer on the rsp side with the six face values. The block takes one item per
// clock cycle unless the output stalls; a result passes from the input register through
// the stage 2 slope registers to the output register. The two beta multipliers per axis
// sit in the first pipeline stage. Stages hold under backpressure and bubbles close up,
// so req_tready only drops once all three stages are full and the output is stalled.
// The user must write slope_beta (byte address 0) through the csr port only while no
// item is in flight; the block does not enforce this. Its reset value is 1.0.
module minmod_slope_face_reconstruction (
   input  logic                                  clock,
   input  logic                                  reset,
   // center, east, west, north, south, top, bottom values, 32 bits each from bit 0 up
   input  logic [mmsfr_pkg::ReqDataWidth-1:0]    req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // east, west, north, south, top, bottom faces, 32 bits each from bit 0 up
   output logic [mmsfr_pkg::RspDataWidth-1:0]    rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mmsfr_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [mmsfr_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [mmsfr_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   localparam int DW = mmsfr_pkg::DataWidth;

   logic [mmsfr_pkg::BetaWidth-1:0] slope_beta_ff, slope_beta_in;
   logic csr_write, csr_hit;

   logic [mmsfr_pkg::ReqDataWidth-1:0] in_data_ff;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   mmsfr_pkg::data_type center_s2_ff;
   logic [mmsfr_pkg::RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic req_accept, out_ready, out_load, s2_free, s2_load, s1_free;

   mmsfr_pkg::data_type center_s1;
   mmsfr_pkg::data_type east_face, west_face, north_face;
   mmsfr_pkg::data_type south_face, top_face, bottom_face;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[mmsfr_pkg::CsrAddrWidth-1:2] == mmsfr_pkg::CsrIdxSlopeBeta;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign slope_beta_in = (csr_write && csr_hit) ? csr_pwdata[mmsfr_pkg::BetaWidth-1:0]
                                                 : slope_beta_ff;
   assign csr_prdata = csr_hit ? mmsfr_pkg::CsrDataWidth'(slope_beta_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_beta_ff <= mmsfr_pkg::BetaReset;
      end else begin
         slope_beta_ff <= slope_beta_in;
      end
   end

   // pipeline flow control: a stage loads when its downstream is empty or draining
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign out_load   = s2_valid_ff && out_ready;
   assign s2_free    = !s2_valid_ff || out_ready;
   assign s2_load    = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = s2_load ? 1'b1 : (out_load ? 1'b0 : s2_valid_ff);
   assign out_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign center_s1 = in_data_ff[DW-1:0];

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_tdata;
      end
      if (s2_load) begin
         center_s2_ff <= center_s1;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   mmsfr_axis u_axis_x (
      .clock        (clock),
      .stage_load   (s2_load),
      .center_value (center_s1),
      .plus_value   (in_data_ff[2*DW-1:DW]),
      .minus_value  (in_data_ff[3*DW-1:2*DW]),
      .slope_beta   (slope_beta_ff),
      .center_hold  (center_s2_ff),
      .plus_face    (east_face),
      .minus_face   (west_face)
   );

   mmsfr_axis u_axis_y (
      .clock        (clock),
      .stage_load   (s2_load),
      .center_value (center_s1),
      .plus_value   (in_data_ff[4*DW-1:3*DW]),
      .minus_value  (in_data_ff[5*DW-1:4*DW]),
      .slope_beta   (slope_beta_ff),
      .center_hold  (center_s2_ff),
      .plus_face    (north_face),
      .minus_face   (south_face)
   );

   mmsfr_axis u_axis_z (
      .clock        (clock),
      .stage_load   (s2_load),
      .center_value (center_s1),
      .plus_value   (in_data_ff[6*DW-1:5*DW]),
      .minus_value  (in_data_ff[7*DW-1:6*DW]),
      .slope_beta   (slope_beta_ff),
      .center_hold  (center_s2_ff),
      .plus_face    (top_face),
      .minus_face   (bottom_face)
   );

   assign rsp_data_in = {bottom_face, top_face, south_face, north_face, west_face, east_face};
   assign rsp_tdata   = rsp_data_ff;
   assign rsp_tvalid  = out_valid_ff;

   // an item leaving stage 1 always lands in stage 2
   assert property (@(posedge clock) disable iff (reset)
      s2_load |=> s2_valid_ff)
      else $error("stage 2 lost an item loaded from stage 1");

   // stage 2 holds its item while the output register is stalled
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_ready) |=> (s2_valid_ff && $stable(center_s2_ff)))
      else $error("stage 2 dropped or changed an item under backpressure");

   // an empty front end never refuses a transfer
   assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !s2_valid_ff) |-> req_tready)
      else $error("req_tready low with empty pipeline");

   // a write to slope_beta takes effect on the next edge
   assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_hit) |=>
         (slope_beta_ff == $past(csr_pwdata[mmsfr_pkg::BetaWidth-1:0])))
      else $error("slope_beta write not taken");

endmodule
